// ----- sv/itnj_pkg.sv -----
// shared types, constants and helper functions for the instance noise jitter block
`timescale 1ns / 1ps

package itnj_pkg;

    // sizes
    localparam int INDEX_BITS_DEF = 16;
    localparam int QDEPTH         = 4;
    localparam int QPTR_W         = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 21;
    localparam int IN_DATA_W      = 216;
    localparam int OUT_DATA_W     = 192;
    localparam int EL_W           = 40;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS  = 3'd0,
        REG_ROT  = 3'd1,
        REG_SCL  = 3'd2,
        REG_RATE = 3'd3,
        REG_SEED = 3'd4
    } cfg_reg_t;

    // register reset values
    localparam logic [17:0] POS_RST  = 18'd3277;
    localparam logic [18:0] ROT_RST  = 19'd0;
    localparam logic [17:0] SCL_RST  = 18'd0;
    localparam logic [20:0] RATE_RST = 21'd65536;
    localparam logic [16:0] SEED_RST = 17'd42;

    // hash and phase constants
    localparam logic [31:0] HASH_MUL1 = 32'd747796405;
    localparam logic [31:0] HASH_ADD  = 32'd2891336453;
    localparam logic [31:0] HASH_MUL2 = 32'd277803737;
    localparam logic [12:0] KEY_STEP  = 13'd7919;
    localparam logic [15:0] GOLDEN    = 16'd40504;
    localparam logic [47:0] OFF_Y     = 48'd2431386;
    localparam logic [47:0] OFF_SCALE = 48'd1920205;
    localparam logic [47:0] OFF_ROT   = 48'd753664;

    // angle and scale constants
    localparam logic signed [20:0] MUL_MIN     = 21'sd3277;
    localparam logic signed [20:0] PI_Q        = 21'sd205887;
    localparam logic signed [20:0] TWO_PI_Q    = 21'sd411775;
    localparam logic signed [20:0] HALF_PI_Q   = 21'sd102944;
    localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;

    // noise sample selector
    typedef enum logic [1:0] {
        TAG_SCL = 2'd0,
        TAG_ROT = 2'd1,
        TAG_X   = 2'd2,
        TAG_Y   = 2'd3
    } ntag_t;

    typedef struct packed {
        logic [17:0] position_amount;
        logic [18:0] rotation_amount;
        logic [17:0] scale_amount;
        logic [20:0] time_rate;
        logic [16:0] noise_seed;
    } cfg_t;

    // one classified item in the queue
    typedef struct packed {
        logic               en_scale;
        logic               en_rot;
        logic               en_pos;
        logic signed [31:0] la;
        logic signed [31:0] lc;
        logic signed [31:0] lb;
        logic signed [31:0] ld;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic [47:0]        phase;
        logic [31:0]        base;
    } item_t;

    typedef struct packed {
        logic        valid;
        ntag_t       tag;
        logic [47:0] phase;
        logic [31:0] key;
    } noise_req_t;

    typedef struct packed {
        logic               valid;
        ntag_t              tag;
        logic signed [16:0] u;
    } noise_rsp_t;

    // arctangent of 2^-i in Q16.16
    function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
        logic signed [19:0] r;
        unique case (i)
            4'd0:    r = 20'sd51472;
            4'd1:    r = 20'sd30386;
            4'd2:    r = 20'sd16055;
            4'd3:    r = 20'sd8150;
            4'd4:    r = 20'sd4091;
            4'd5:    r = 20'sd2047;
            4'd6:    r = 20'sd1024;
            4'd7:    r = 20'sd512;
            4'd8:    r = 20'sd256;
            4'd9:    r = 20'sd128;
            4'd10:   r = 20'sd64;
            4'd11:   r = 20'sd32;
            4'd12:   r = 20'sd16;
            4'd13:   r = 20'sd8;
            4'd14:   r = 20'sd4;
            default: r = 20'sd2;
        endcase
        return r;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [EL_W-1:0] v);
        logic [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/instance_transform_noise_jitter.sv -----
// top level: config registers, front end, item queue, noise unit and back end
//
//  channel  | direction | valid/ready          | payload
//  ---------+-----------+----------------------+-------------------------------
//  s_       | in        | s_tvalid / s_tready  | s_tuser, s_tdata (216 b)
//  m_       | out       | m_tvalid / m_tready  | m_tdata (192 b)
//  cfg_     | in        | cfg_we (no ready)    | cfg_index, cfg_data (21 b)
//
// An item passes through the back end in order: pop, gather of four noise
// samples through the 3-stage hash pipeline, scale and angle reduction,
// the 16 CORDIC iterations, rotation and translation, and output.
// The back end takes a new item from the queue only once it is idle again.
// The front accepts up to 4 items ahead into the queue; a stalled output only
// holds the back end, the front keeps accepting until the queue is full.
// Reset is synchronous; it clears time, instance index and queue and loads the config reset values.
`timescale 1ns / 1ps

module instance_transform_noise_jitter #(
    parameter int INDEX_BITS = itnj_pkg::INDEX_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [itnj_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [itnj_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              s_tuser,   // frame_start
    // frame_delta, lin_a, lin_c, lin_b, lin_d, move_x, move_y, zero pad
    input  logic [itnj_pkg::IN_DATA_W-1:0]    s_tdata,
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_a, out_c, out_b, out_d, out_x, out_y
    output logic [itnj_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import itnj_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       q_full, q_empty, q_push, q_pop;
    item_t      q_in, q_out;
    noise_req_t n_req;
    noise_rsp_t n_rsp;

    // register writes, unknown indexes ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_POS:  cfg_next.position_amount = cfg_data[17:0];
                REG_ROT:  cfg_next.rotation_amount = cfg_data[18:0];
                REG_SCL:  cfg_next.scale_amount    = cfg_data[17:0];
                REG_RATE: cfg_next.time_rate       = cfg_data[20:0];
                REG_SEED: cfg_next.noise_seed      = cfg_data[16:0];
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.position_amount <= POS_RST;
            cfg_reg.rotation_amount <= ROT_RST;
            cfg_reg.scale_amount    <= SCL_RST;
            cfg_reg.time_rate       <= RATE_RST;
            cfg_reg.noise_seed      <= SEED_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    itnj_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    itnj_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out),
        .empty     (q_empty)
    );

    itnj_noise u_noise (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (n_req),
        .rsp     (n_rsp)
    );

    itnj_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_item   (q_out),
        .q_pop    (q_pop),
        .n_req    (n_req),
        .n_rsp    (n_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- sv/itnj_fifo.sv -----
// short item queue between the front and the back
`timescale 1ns / 1ps

module itnj_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  itnj_pkg::item_t push_item,
    output logic          full,
    input  logic          pop,
    output itnj_pkg::item_t pop_item,
    output logic          empty
);
    import itnj_pkg::*;

    item_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + (push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (pop ? 1'b1 : 1'b0);
        count_next  = count_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- sv/itnj_front.sv -----
// front end: takes requests, keeps time and index, builds phase and hash base
`timescale 1ns / 1ps

module itnj_front #(
    parameter int INDEX_BITS = itnj_pkg::INDEX_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  itnj_pkg::cfg_t                    cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              s_tuser,
    input  logic [itnj_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              q_full,
    output logic                              q_push,
    output itnj_pkg::item_t                   q_item
);
    import itnj_pkg::*;

    logic [47:0]           time_reg, time_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;

    logic [16:0]            frame_delta;
    logic [37:0]            dt_prod;
    logic [47:0]            cur_time;
    logic [INDEX_BITS-1:0]  idx;
    logic [INDEX_BITS+15:0] idx_gold;
    logic [INDEX_BITS+12:0] idx_key;

    assign s_tready    = !q_full;
    assign q_push      = s_tvalid && s_tready;
    assign frame_delta = s_tdata[16:0];

    // time advance and index restart on frame start
    always_comb begin
        dt_prod  = frame_delta * cfg.time_rate;
        cur_time = s_tuser ? (time_reg + 48'(dt_prod[37:16])) : time_reg;
        idx      = s_tuser ? '0 : idx_reg;
        idx_gold = idx * GOLDEN;
        idx_key  = idx * KEY_STEP;
        time_next = q_push ? cur_time : time_reg;
        idx_next  = q_push ? (idx + 1'b1) : idx_reg;
    end

    // classify and pack the item
    always_comb begin
        q_item.en_scale = (cfg.scale_amount != '0);
        q_item.en_rot   = (cfg.rotation_amount != '0);
        q_item.en_pos   = (cfg.position_amount != '0);
        q_item.la       = s_tdata[48:17];
        q_item.lc       = s_tdata[80:49];
        q_item.lb       = s_tdata[112:81];
        q_item.ld       = s_tdata[144:113];
        q_item.mx       = s_tdata[176:145];
        q_item.my       = s_tdata[208:177];
        q_item.phase    = cur_time + 48'(idx_gold);
        q_item.base     = 32'(idx_key) + 32'(cfg.noise_seed);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
            idx_reg  <= '0;
        end else begin
            time_reg <= time_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

// ----- sv/itnj_noise.sv -----
// three-stage smooth value noise: two hash lanes plus smoothstep blend
`timescale 1ns / 1ps

module itnj_noise (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  itnj_pkg::noise_req_t req,
    output itnj_pkg::noise_rsp_t rsp
);
    import itnj_pkg::*;

    logic        v1_reg, v2_reg, v3_reg;
    ntag_t       t1_reg, t2_reg, t3_reg;
    logic [31:0] st0_reg, st1_reg, w0_reg, w1_reg;
    logic [15:0] f1_reg, f2_reg;
    logic [16:0] s_reg;
    logic signed [16:0] u_reg;

    logic [31:0] k0, k1, ff;
    logic [4:0]  sh0, sh1;
    logic [33:0] sp;
    logic [15:0] hv0, hv1;
    logic [31:0] x0, x1;
    logic [33:0] np;
    logic signed [17:0] ut;

    // stage 0: hash keys and f squared
    always_comb begin
        k0 = req.phase[47:16] + req.key;
        k1 = k0 + 32'd1;
        ff = req.phase[15:0] * req.phase[15:0];
    end

    // stage 1: shift-xor and second multiply, smoothstep weight
    always_comb begin
        sh0 = {1'b0, st0_reg[31:28]} + 5'd4;
        sh1 = {1'b0, st1_reg[31:28]} + 5'd4;
        sp  = f2_reg * (18'd196608 - {1'b0, f1_reg, 1'b0});
    end

    // stage 2: final xor and blend
    always_comb begin
        x0  = (w0_reg >> 22) ^ w0_reg;
        x1  = (w1_reg >> 22) ^ w1_reg;
        hv0 = x0[31:16];
        hv1 = x1[31:16];
        np  = hv0 * (17'd65536 - s_reg) + hv1 * s_reg;
        ut  = $signed({1'b0, np[31:16], 1'b0}) - 18'sd65536;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        t1_reg  <= req.tag;
        st0_reg <= k0 * HASH_MUL1 + HASH_ADD;
        st1_reg <= k1 * HASH_MUL1 + HASH_ADD;
        f1_reg  <= req.phase[15:0];
        f2_reg  <= ff[31:16];
        t2_reg  <= t1_reg;
        w0_reg  <= ((st0_reg >> sh0) ^ st0_reg) * HASH_MUL2;
        w1_reg  <= ((st1_reg >> sh1) ^ st1_reg) * HASH_MUL2;
        s_reg   <= sp[32:16];
        t3_reg  <= t2_reg;
        u_reg   <= ut[16:0];
    end

    assign rsp.valid = v3_reg;
    assign rsp.tag   = t3_reg;
    assign rsp.u     = u_reg;

endmodule

// ----- sv/itnj_back.sv -----
// back end: noise gather, scale, cordic rotation, translation, output register
`timescale 1ns / 1ps

module itnj_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  itnj_pkg::cfg_t                   cfg,
    input  logic                             q_empty,
    input  itnj_pkg::item_t                  q_item,
    output logic                             q_pop,
    output itnj_pkg::noise_req_t             n_req,
    input  itnj_pkg::noise_rsp_t             n_rsp,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [itnj_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import itnj_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_NOISE  = 9'b000000010,
        ST_SCALE  = 9'b000000100,
        ST_SMUL   = 9'b000001000,
        ST_REDUCE = 9'b000010000,
        ST_CORDIC = 9'b000100000,
        ST_ROT    = 9'b001000000,
        ST_ROT2   = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        ovalid_reg, ovalid_next;
    logic        out_free, out_load;

    item_t              item_reg;
    logic signed [16:0] u_scl_reg, u_rot_reg, u_x_reg, u_y_reg;
    logic signed [19:0] mul_reg;
    logic signed [20:0] th_reg;
    logic signed [EL_W-1:0] ea_reg, ec_reg, eb_reg, ed_reg;
    logic signed [19:0] cx_reg, cy_reg, cz_reg;
    logic               neg_reg;
    logic signed [59:0] pca_reg, psc_reg, psa_reg, pcc_reg;
    logic signed [59:0] pcb_reg, psd_reg, psb_reg, pcd_reg;
    logic signed [19:0] dx_reg, dy_reg;
    logic signed [33:0] x_reg, y_reg;
    logic [OUT_DATA_W-1:0] out_reg;

    logic signed [35:0] ps, ppx, ppy;
    logic signed [20:0] mul_raw;
    logic signed [19:0] mul_c;
    logic signed [51:0] pa, pc, pb, pd;
    logic signed [36:0] pt;
    logic signed [20:0] th1, th2;
    logic               fold;
    logic signed [19:0] dxc, dyc, atv, cs, sn;
    logic signed [60:0] ra, rc, rb, rd;

    assign out_free = !ovalid_reg || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;

    // noise requests, one per cycle at noise counts 0 to 3, one for each of the four samples
    always_comb begin
        n_req.valid = (state_reg == ST_NOISE) && (cnt_reg[3:2] == 2'b00);
        n_req.tag   = ntag_t'(cnt_reg[1:0]);
        unique case (n_req.tag)
            TAG_SCL: begin
                n_req.phase = item_reg.phase + OFF_SCALE;
                n_req.key   = item_reg.base + 32'd5;
            end
            TAG_ROT: begin
                n_req.phase = item_reg.phase + OFF_ROT;
                n_req.key   = item_reg.base + 32'd3;
            end
            TAG_X: begin
                n_req.phase = item_reg.phase;
                n_req.key   = item_reg.base;
            end
            default: begin
                n_req.phase = item_reg.phase + OFF_Y;
                n_req.key   = item_reg.base + 32'd1;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (!q_empty) begin
                    state_next = ST_NOISE;
                end
            end
            ST_NOISE: begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd6) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:  state_next = ST_SMUL;
            ST_SMUL:   state_next = ST_REDUCE;
            ST_REDUCE: begin
                cnt_next   = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT:  state_next = ST_ROT2;
            ST_ROT2: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output valid
    always_comb begin
        if (out_load) begin
            ovalid_next = 1'b1;
        end else if (m_tready) begin
            ovalid_next = 1'b0;
        end else begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // scale factor and rotation angle
    always_comb begin
        ps      = $signed({1'b0, cfg.scale_amount}) * u_scl_reg;
        mul_raw = {ps[35], ps[35:16]} + 21'sd65536;
        mul_c   = (mul_raw < MUL_MIN) ? MUL_MIN[19:0] : mul_raw[19:0];
        pa      = item_reg.la * mul_reg;
        pc      = item_reg.lc * mul_reg;
        pb      = item_reg.lb * mul_reg;
        pd      = item_reg.ld * mul_reg;
        pt      = $signed({1'b0, cfg.rotation_amount}) * u_rot_reg;
    end

    // angle range reduction and fold into the right half plane
    always_comb begin
        if (th_reg > PI_Q) begin
            th1 = th_reg - TWO_PI_Q;
        end else if (th_reg < -PI_Q) begin
            th1 = th_reg + TWO_PI_Q;
        end else begin
            th1 = th_reg;
        end
        fold = 1'b1;
        if (th1 > HALF_PI_Q) begin
            th2 = th1 - PI_Q;
        end else if (th1 < -HALF_PI_Q) begin
            th2 = th1 + PI_Q;
        end else begin
            th2  = th1;
            fold = 1'b0;
        end
    end

    // one cordic iteration and the rotation products
    always_comb begin
        dxc = cy_reg >>> cnt_reg;
        dyc = cx_reg >>> cnt_reg;
        atv = atan_q16(cnt_reg);
        cs  = neg_reg ? -cx_reg : cx_reg;
        sn  = neg_reg ? -cy_reg : cy_reg;
        ppx = $signed({1'b0, cfg.position_amount}) * u_x_reg;
        ppy = $signed({1'b0, cfg.position_amount}) * u_y_reg;
        ra  = pca_reg - psc_reg;
        rc  = psa_reg + pcc_reg;
        rb  = pcb_reg - psd_reg;
        rd  = psb_reg + pcd_reg;
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
        end
        if (n_rsp.valid) begin
            unique case (n_rsp.tag)
                TAG_SCL: u_scl_reg <= n_rsp.u;
                TAG_ROT: u_rot_reg <= n_rsp.u;
                TAG_X:   u_x_reg   <= n_rsp.u;
                default: u_y_reg   <= n_rsp.u;
            endcase
        end
        if (state_reg == ST_SCALE) begin
            mul_reg <= mul_c;
        end
        if (state_reg == ST_SMUL) begin
            th_reg <= pt[36:16];
            if (item_reg.en_scale) begin
                ea_reg <= EL_W'($signed(pa[51:16]));
                ec_reg <= EL_W'($signed(pc[51:16]));
                eb_reg <= EL_W'($signed(pb[51:16]));
                ed_reg <= EL_W'($signed(pd[51:16]));
            end else begin
                ea_reg <= EL_W'(item_reg.la);
                ec_reg <= EL_W'(item_reg.lc);
                eb_reg <= EL_W'(item_reg.lb);
                ed_reg <= EL_W'(item_reg.ld);
            end
        end
        if (state_reg == ST_REDUCE) begin
            cx_reg  <= CORDIC_GAIN;
            cy_reg  <= '0;
            cz_reg  <= th2[19:0];
            neg_reg <= fold;
        end
        if (state_reg == ST_CORDIC) begin
            if (cz_reg >= 0) begin
                cx_reg <= cx_reg - dxc;
                cy_reg <= cy_reg + dyc;
                cz_reg <= cz_reg - atv;
            end else begin
                cx_reg <= cx_reg + dxc;
                cy_reg <= cy_reg - dyc;
                cz_reg <= cz_reg + atv;
            end
        end
        if (state_reg == ST_ROT) begin
            pca_reg <= cs * ea_reg;
            psc_reg <= sn * ec_reg;
            psa_reg <= sn * ea_reg;
            pcc_reg <= cs * ec_reg;
            pcb_reg <= cs * eb_reg;
            psd_reg <= sn * ed_reg;
            psb_reg <= sn * eb_reg;
            pcd_reg <= cs * ed_reg;
            dx_reg  <= ppx[35:16];
            dy_reg  <= ppy[35:16];
        end
        if (state_reg == ST_ROT2) begin
            if (item_reg.en_rot) begin
                ea_reg <= ra[55:16];
                ec_reg <= rc[55:16];
                eb_reg <= rb[55:16];
                ed_reg <= rd[55:16];
            end
            if (item_reg.en_pos) begin
                x_reg <= 34'(item_reg.mx) + 34'(dx_reg);
                y_reg <= 34'(item_reg.my) + 34'(dy_reg);
            end else begin
                x_reg <= 34'(item_reg.mx);
                y_reg <= 34'(item_reg.my);
            end
        end
        if (out_load) begin
            out_reg <= {sat32(EL_W'(y_reg)), sat32(EL_W'(x_reg)),
                        sat32(ed_reg), sat32(eb_reg), sat32(ec_reg), sat32(ea_reg)};
        end
    end

endmodule

// ----- sv/itnj_checker.sv -----
// port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps

module itnj_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [itnj_pkg::OUT_DATA_W-1:0]  m_tdata
);

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // no result can come out of the pipeline right after reset release
    a_quiet_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid ##1 !m_tvalid)
        else $error("result too soon after reset");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind instance_transform_noise_jitter itnj_checker u_itnj_checker (.*);

// ----- tb/tb_instance_transform_noise_jitter.sv -----
// testbench for the instance transform noise jitter block: directed and random requests
`timescale 1ns / 1ps

module tb_instance_transform_noise_jitter;
    import itnj_pkg::*;

    typedef struct packed {
        logic [31:0] oy;
        logic [31:0] ox;
        logic [31:0] od;
        logic [31:0] ob;
        logic [31:0] oc;
        logic [31:0] oa;
    } xform_out_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic s_tuser;                   // frame_start
    // frame_delta, lin_a, lin_c, lin_b, lin_d, move_x, move_y, zero pad
    logic [IN_DATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    // out_a, out_c, out_b, out_d, out_x, out_y
    logic [OUT_DATA_W-1:0] m_tdata;

    // predictor copy of registers and state
    logic [17:0] pos_amt;
    logic [18:0] rot_amt;
    logic [17:0] scl_amt;
    logic [20:0] rate;
    logic [16:0] seed;
    logic [47:0] anim_time;
    logic [15:0] inst_idx;

    xform_out_t jitter_q[$];
    int errors;
    int stall_mode;

    instance_transform_noise_jitter u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // floored arithmetic shift right
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [15:0] pcg_sample(input logic [31:0] key);
        logic [31:0] st;
        logic [31:0] w;
        st = key * HASH_MUL1 + HASH_ADD;
        w = ((st >> ((st >> 28) + 4)) ^ st) * HASH_MUL2;
        return 16'(((w >> 22) ^ w) >> 16);
    endfunction

    // smoothstep value noise, bipolar Q0.16
    function automatic longint smooth_noise(input logic [47:0] ph, input logic [31:0] key);
        logic [31:0] p;
        longint f, v0, v1, f2, s, n;
        p = ph[47:16];
        f = ph[15:0];
        v0 = pcg_sample(p + key);
        v1 = pcg_sample(p + 32'd1 + key);
        f2 = (f * f) >> 16;
        s = (f2 * (196608 - 2 * f)) >> 16;
        n = (v0 * (65536 - s) + v1 * s) >> 16;
        return 2 * n - 65536;
    endfunction

    function automatic longint arctan_step(input int i);
        longint t[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};
        return t[i];
    endfunction

    task automatic cordic_sincos(input longint theta, output longint cs, output longint sn);
        bit flip;
        longint x, y, z, dx, dy;
        flip = 0;
        x = 39797;
        y = 0;
        while (theta > 205887) theta -= 411775;
        while (theta < -205887) theta += 411775;
        if (theta > 102944) begin
            theta -= 205887;
            flip = 1;
        end else if (theta < -102944) begin
            theta += 205887;
            flip = 1;
        end
        z = theta;
        for (int i = 0; i < 16; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endtask

    // expected transform for one accepted request
    task automatic predict_jitter(input logic fs, input logic [IN_DATA_W-1:0] d);
        longint a, c, b, dd, x, y, u, mul, th, cs, sn, na, nc, nb, nd;
        logic [47:0] ph;
        logic [31:0] base;
        xform_out_t r;
        a = $signed(d[48:17]);
        c = $signed(d[80:49]);
        b = $signed(d[112:81]);
        dd = $signed(d[144:113]);
        x = $signed(d[176:145]);
        y = $signed(d[208:177]);
        if (fs) begin
            anim_time = anim_time + 48'((64'(d[16:0]) * 64'(rate)) >> 16);
            inst_idx = 0;
        end
        ph = anim_time + 48'(inst_idx) * 48'd40504;
        base = 32'(inst_idx) * 32'd7919 + 32'(seed);
        if (scl_amt != 0) begin
            u = smooth_noise(ph + OFF_SCALE, base + 5);
            mul = 65536 + floor_shr(longint'(scl_amt) * u, 16);
            if (mul < 3277) mul = 3277;
            a = floor_shr(a * mul, 16); c = floor_shr(c * mul, 16);
            b = floor_shr(b * mul, 16); dd = floor_shr(dd * mul, 16);
        end
        if (rot_amt != 0) begin
            u = smooth_noise(ph + OFF_ROT, base + 3);
            th = floor_shr(longint'(rot_amt) * u, 16);
            cordic_sincos(th, cs, sn);
            na = floor_shr(cs * a - sn * c, 16);
            nc = floor_shr(sn * a + cs * c, 16);
            nb = floor_shr(cs * b - sn * dd, 16);
            nd = floor_shr(sn * b + cs * dd, 16);
            a = na; c = nc; b = nb; dd = nd;
        end
        if (pos_amt != 0) begin
            x += floor_shr(longint'(pos_amt) * smooth_noise(ph, base), 16);
            y += floor_shr(longint'(pos_amt) * smooth_noise(ph + OFF_Y, base + 1), 16);
        end
        r.oa = clamp32(a); r.oc = clamp32(c); r.ob = clamp32(b);
        r.od = clamp32(dd); r.ox = clamp32(x); r.oy = clamp32(y);
        jitter_q = {jitter_q, r};
        inst_idx = inst_idx + 16'd1;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // write one register while idle
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        unique case (idx)
            REG_POS:  pos_amt = v[17:0];
            REG_ROT:  rot_amt = v[18:0];
            REG_SCL:  scl_amt = v[17:0];
            REG_RATE: rate = v[20:0];
            REG_SEED: seed = v[16:0];
            default: ;
        endcase
    endtask

    // idle the input, wait until all results are back plus pipeline drain
    task automatic drain();
        s_tvalid <= 1'b0;
        while (jitter_q.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // send one request, called at a falling edge; valid stays up until the caller idles
    task automatic send_xform(input logic fs, input logic [16:0] dt,
                              input logic [31:0] la, input logic [31:0] lc,
                              input logic [31:0] lb, input logic [31:0] ld,
                              input logic [31:0] mx, input logic [31:0] my);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[208:0] = {my, mx, ld, lb, lc, la, dt};
        s_tvalid <= 1'b1;
        s_tuser <= fs;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_jitter(fs, d);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_elem();
        unique case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    task automatic rand_xform(input logic fs);
        send_xform(fs, 17'($urandom_range(0, 65536)), rand_elem(), rand_elem(),
                   rand_elem(), rand_elem(), rand_elem(), rand_elem());
    endtask

    // random bursts and gaps, mostly frames of instances
    task automatic random_burst(input int n);
        int left;
        left = n;
        while (left > 0) begin
            for (int k = $urandom_range(1, 12); k > 0 && left > 0; k--) begin
                rand_xform($urandom_range(0, 15) == 0);
                left--;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(negedge aclk);
            end
        end
    endtask

    task automatic test_reset_values();
        send_xform(1'b1, 17'd65536, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000,
                   32'd0, 32'd0);
        send_xform(1'b0, 17'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_xform(1'b0, 17'd65536, 32'hFFFF_FFFF, 32'd1, 32'h0000_8000, 32'hFFFF_0000,
                   32'h8000_0000, 32'h7FFF_FFFF);
        drain();
    endtask

    task automatic test_extremes();
        write_reg(REG_POS, 21'd131072);
        write_reg(REG_ROT, 21'd411775);
        write_reg(REG_SCL, 21'd131072);
        write_reg(REG_RATE, 21'd1310720);
        write_reg(REG_SEED, 21'd99999);
        send_xform(1'b1, 17'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int i = 0; i < 6; i++) rand_xform(1'b0);
        send_xform(1'b1, 17'd0, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000,
                   32'd0, 32'd0);
        drain();
        // full-width values beyond documented ranges and bad indexes
        write_reg(REG_POS, 21'h1F_FFFF);
        write_reg(REG_ROT, 21'h1F_FFFF);
        write_reg(REG_SCL, 21'h1F_FFFF);
        write_reg(REG_RATE, 21'h1F_FFFF);
        write_reg(REG_SEED, 21'h1F_FFFF);
        write_reg(cfg_reg_t'(3'd7), 21'h15_5555);
        write_reg(cfg_reg_t'(3'd5), 21'h0A_AAAA);
        for (int i = 0; i < 8; i++) rand_xform(i == 0);
        drain();
        // all jitter off
        write_reg(REG_POS, 21'd0);
        write_reg(REG_ROT, 21'd0);
        write_reg(REG_SCL, 21'd0);
        write_reg(REG_RATE, 21'd0);
        write_reg(REG_SEED, 21'd0);
        for (int i = 0; i < 4; i++) rand_xform(i == 0);
        drain();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_POS, 21'($urandom_range(0, 131072)));
            write_reg(REG_ROT, 21'($urandom_range(0, 1) ? $urandom_range(0, 411775)
                                                         : $urandom_range(0, 524287)));
            write_reg(REG_SCL, 21'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 262143)));
            write_reg(REG_RATE, 21'($urandom));
            write_reg(REG_SEED, 21'($urandom_range(0, 131071)));
            stall_mode = ph % 4;
            random_burst(100);
            drain();
        end
    endtask

    // long frame of instances after a single frame start
    task automatic test_long_frame();
        write_reg(REG_SCL, 21'd0);
        write_reg(REG_ROT, 21'd0);
        write_reg(REG_POS, 21'd65536);
        stall_mode = 0;
        rand_xform(1'b1);
        for (int i = 0; i < 29; i++) rand_xform(1'b0);
        drain();
    endtask

    // receiver stall pattern
    always @(negedge aclk) begin
        unique case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // result checker
    always @(posedge aclk) begin
        xform_out_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (jitter_q.size() == 0) begin
                report_mismatch("unexpected result", got.oa, 32'h0);
            end else begin
                want = jitter_q.pop_front();
                if (got.oa !== want.oa) report_mismatch("out_a", got.oa, want.oa);
                if (got.oc !== want.oc) report_mismatch("out_c", got.oc, want.oc);
                if (got.ob !== want.ob) report_mismatch("out_b", got.ob, want.ob);
                if (got.od !== want.od) report_mismatch("out_d", got.od, want.od);
                if (got.ox !== want.ox) report_mismatch("out_x", got.ox, want.ox);
                if (got.oy !== want.oy) report_mismatch("out_y", got.oy, want.oy);
            end
        end
    end

    initial begin
        errors = 0;
        stall_mode = 1;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        pos_amt = 18'd3277;
        rot_amt = 0;
        scl_amt = 0;
        rate = 21'd65536;
        seed = 17'd42;
        anim_time = 0;
        inst_idx = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_values();
        test_extremes();
        test_random_settings();
        test_long_frame();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // run time limit
    initial begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
sv/itnj_pkg.sv
sv/itnj_fifo.sv
sv/itnj_front.sv
sv/itnj_noise.sv
sv/itnj_back.sv
sv/instance_transform_noise_jitter.sv
sv/itnj_checker.sv
tb/tb_instance_transform_noise_jitter.sv
